FILE: hdl/h8se_pkg.sv
// Shared types and constants for the hexahedron shape function unit.
package h8se_pkg;

  localparam int COORD_W = 16;
  localparam int NODE_W  = 3;
  localparam int RES_W   = 15;

  // Point queue between front and back; the depth must be a power of two.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [NODE_W-1:0] NODE_FIRST = 3'd0;
  localparam logic [NODE_W-1:0] NODE_LAST  = 3'd7;

  localparam logic [RES_W-1:0] SHAPE_MAX   = 15'd32767;
  localparam int               DER_POS_MAX = 16383;
  localparam int               DER_NEG_MAG = 16384;

  typedef struct packed {
    logic signed [COORD_W-1:0] xi;
    logic signed [COORD_W-1:0] eta;
    logic signed [COORD_W-1:0] zeta;
  } point_t;

endpackage

FILE: hdl/h8se_front.sv
// Input side: takes a point beat, clamps each coordinate to [-1,1] and pushes it.
module h8se_front #(
  parameter int FRAC_BITS = 14
) (
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [h8se_pkg::COORD_W-1:0] in_xi_coord,
  input  logic signed [h8se_pkg::COORD_W-1:0] in_eta_coord,
  input  logic signed [h8se_pkg::COORD_W-1:0] in_zeta_coord,
  input  logic                           q_full,
  output logic                           q_push,
  output h8se_pkg::point_t               q_entry
);
  import h8se_pkg::*;

  localparam int signed ONE = 1 << FRAC_BITS;

  // With more than 14 fraction bits no 16-bit value lies outside [-1,1].
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [COORD_W-1:0] x
  );
    logic signed [COORD_W-1:0] r;
    r = x;
    if (int'(x) > ONE) begin
      r = COORD_W'(ONE);
    end else if (int'(x) < -ONE) begin
      r = COORD_W'(-ONE);
    end
    return r;
  endfunction

  assign in_stall     = q_full;
  assign q_push       = in_valid && !q_full;
  assign q_entry.xi   = sat_coord(in_xi_coord);
  assign q_entry.eta  = sat_coord(in_eta_coord);
  assign q_entry.zeta = sat_coord(in_zeta_coord);

endmodule

FILE: hdl/h8se_queue.sv
// Short register queue of clamped points between the front and the back.
module h8se_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  h8se_pkg::point_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output h8se_pkg::point_t head
);
  import h8se_pkg::*;

  point_t             entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: hdl/h8se_back.sv
// Evaluation side: walks nodes 0..7 of the head point through a three-stage pipeline.
module h8se_back #(
  parameter int FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  h8se_pkg::point_t                 q_head,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [h8se_pkg::NODE_W-1:0]      out_node_index,
  output logic [h8se_pkg::RES_W-1:0]       out_shape_value,
  output logic signed [h8se_pkg::RES_W-1:0] out_deriv_xi,
  output logic signed [h8se_pkg::RES_W-1:0] out_deriv_eta,
  output logic signed [h8se_pkg::RES_W-1:0] out_deriv_zeta,
  output logic                             out_last_node
);
  import h8se_pkg::*;

  // Factors (1 +- x) lie in [0, 2.0] and need FRAC_BITS+2 bits.
  localparam int FW   = FRAC_BITS + 2;
  localparam int PW   = 2 * FW;
  localparam int TW   = 3 * FW;
  localparam int DSH  = FRAC_BITS + 3;
  localparam int SSH  = 2 * FRAC_BITS + 3;
  localparam int SW   = TW + 1 - SSH;
  localparam logic [FW-1:0] ONE_F = FW'(1) << FRAC_BITS;
  localparam logic [PW:0]   HALF2 = (PW + 1)'(1) << (DSH - 1);
  localparam logic [TW:0]   HALF3 = (TW + 1)'(1) << (SSH - 1);

  // Round a two-factor product to nearest, ties away from zero, saturate it, then apply the sign.
  function automatic logic [RES_W-1:0] deriv_round(
    input logic [PW-1:0] p,
    input logic          plus
  );
    logic [PW:0]  s;
    logic [31:0]  m;
    logic [31:0]  lim;
    s   = (PW + 1)'(p) + HALF2;
    m   = 32'(s[PW:DSH]);
    lim = plus ? 32'(DER_POS_MAX) : 32'(DER_NEG_MAG);
    if (m > lim) begin
      m = lim;
    end
    return plus ? m[RES_W-1:0] : (RES_W'(0) - m[RES_W-1:0]);
  endfunction

  logic              adv;
  logic              issue;
  logic [NODE_W-1:0] node_cnt_r, node_cnt_nxt;

  logic [FW-1:0]     fx, fy, fz;

  logic              v1_r, v2_r, out_valid_r;
  logic [NODE_W-1:0] node_s1_r, node_s2_r, out_node_r;
  logic [PW-1:0]     pxy_r, pyz_r, pxz_r;
  logic [FW-1:0]     fz_r;

  logic [PW-1:0]     plo_r, phi_r;
  logic [RES_W-1:0]  dxi_r, deta_r, dzeta_r;

  logic [TW-1:0]     p3;
  logic [TW:0]       p3_rnd;
  logic [SW-1:0]     shape_q;
  logic [RES_W-1:0]  shape_nxt;

  logic [RES_W-1:0]  out_shape_r;
  logic [RES_W-1:0]  out_dxi_r, out_deta_r, out_dzeta_r;

  // The whole pipeline holds while a finished result is stalled at the output.
  assign adv   = !out_valid_r || !out_stall;
  assign issue = adv && q_valid;
  assign q_pop = issue && (node_cnt_r == NODE_LAST);

  assign node_cnt_nxt = issue ? node_cnt_r + 1'b1 : node_cnt_r;

  assign fx = node_cnt_r[0] ? ONE_F + FW'(q_head.xi)   : ONE_F - FW'(q_head.xi);
  assign fy = node_cnt_r[1] ? ONE_F + FW'(q_head.eta)  : ONE_F - FW'(q_head.eta);
  assign fz = node_cnt_r[2] ? ONE_F + FW'(q_head.zeta) : ONE_F - FW'(q_head.zeta);

  // The triple product is split at FW bits so each multiplier stays FW by FW.
  assign p3        = TW'(plo_r) + {phi_r, {FW{1'b0}}};
  assign p3_rnd    = (TW + 1)'(p3) + HALF3;
  assign shape_q   = p3_rnd[TW:SSH];
  assign shape_nxt = (64'(shape_q) > 64'(SHAPE_MAX)) ? SHAPE_MAX : shape_q[RES_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r  <= NODE_FIRST;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      node_cnt_r <= node_cnt_nxt;
      if (adv) begin
        v1_r        <= issue;
        v2_r        <= v1_r;
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      node_s1_r   <= node_cnt_r;
      pxy_r       <= fx * fy;
      pyz_r       <= fy * fz;
      pxz_r       <= fx * fz;
      fz_r        <= fz;

      node_s2_r   <= node_s1_r;
      plo_r       <= pxy_r[FW-1:0] * fz_r;
      phi_r       <= pxy_r[PW-1:FW] * fz_r;
      dxi_r       <= deriv_round(pyz_r, node_s1_r[0]);
      deta_r      <= deriv_round(pxz_r, node_s1_r[1]);
      dzeta_r     <= deriv_round(pxy_r, node_s1_r[2]);

      out_node_r  <= node_s2_r;
      out_shape_r <= shape_nxt;
      out_dxi_r   <= dxi_r;
      out_deta_r  <= deta_r;
      out_dzeta_r <= dzeta_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_node_index  = out_node_r;
  assign out_shape_value = out_shape_r;
  assign out_deriv_xi    = out_dxi_r;
  assign out_deriv_eta   = out_deta_r;
  assign out_deriv_zeta  = out_dzeta_r;
  assign out_last_node   = (out_node_r == NODE_LAST);

`ifndef SYNTH
  // Nodes that sit in adjacent stages were issued back to back.
  a_node_order: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r |-> node_s1_r == node_s2_r + 1'b1)
    else $error("pipeline node order broken");

  // A stalled first stage keeps its node.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !adv |=> v1_r && $stable(node_s1_r))
    else $error("first stage changed during stall");

  // Where the format can hold 1.0, the shape value never exceeds it.
  a_shape_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (FRAC_BITS <= 14) |-> out_shape_r <= RES_W'(ONE_F))
    else $error("shape value above one");

  // The xi derivative carries the sign of the node's xi side.
  a_dxi_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_node_r[0] && !out_dxi_r[RES_W-1]) ||
                    (!out_node_r[0] && (out_dxi_r[RES_W-1] || out_dxi_r == '0)))
    else $error("xi derivative has the wrong sign");
`endif

endmodule

FILE: hdl/hex8_shape_and_derivative_eval_unit.sv
// Top level of the 8-node hexahedron shape function and derivative unit.
// The result for node 0 is registered in the queue and then in each back-end pipeline stage.
// Throughput: one node result per cycle while out_stall is low, set by the single
// output channel that carries the eight node results of each point.
// A two-entry point queue lets new points enter while results are still stalled.
// Reset: synchronous active-low rst_n empties the queue and the pipeline.
module hex8_shape_and_derivative_eval_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [h8se_pkg::COORD_W-1:0] in_xi_coord,
  input  logic signed [h8se_pkg::COORD_W-1:0] in_eta_coord,
  input  logic signed [h8se_pkg::COORD_W-1:0] in_zeta_coord,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [h8se_pkg::NODE_W-1:0]       out_node_index,
  output logic [h8se_pkg::RES_W-1:0]        out_shape_value,
  output logic signed [h8se_pkg::RES_W-1:0] out_deriv_xi,
  output logic signed [h8se_pkg::RES_W-1:0] out_deriv_eta,
  output logic signed [h8se_pkg::RES_W-1:0] out_deriv_zeta,
  output logic                              out_last_node
);
  import h8se_pkg::*;

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_not_empty;
  point_t q_entry;
  point_t q_head;

  h8se_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_xi_coord   (in_xi_coord),
    .in_eta_coord  (in_eta_coord),
    .in_zeta_coord (in_zeta_coord),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  h8se_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  h8se_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_node_index  (out_node_index),
    .out_shape_value (out_shape_value),
    .out_deriv_xi    (out_deriv_xi),
    .out_deriv_eta   (out_deriv_eta),
    .out_deriv_zeta  (out_deriv_zeta),
    .out_last_node   (out_last_node)
  );

endmodule
